FILE: src/kmer_count_table_top_macros.svh
// assertion macros used by the checker file
`ifndef KMER_COUNT_TABLE_TOP_MACROS_SVH
`define KMER_COUNT_TABLE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define KCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmer count table check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define KCT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmer count table check failed");

`endif

FILE: src/kct_pkg.sv
`timescale 1ns / 1ps

package kct_pkg;

  localparam int CMD_W      = 2;
  localparam int KMER_W     = 64;
  localparam int COUNT_W    = 31;
  localparam int TALLY_W    = 17;
  localparam int MAXK_W     = 16;
  localparam int BIN_W      = 6;
  localparam int KEYB_W     = 5;
  localparam int BINS_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int Q_DEPTH    = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  localparam logic [KEYB_W-1:0] KEY_BITS_RST = 5'd16;
  localparam logic [BINS_W-1:0] BINS_RST     = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BITS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECTRUM_BINS = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD      = 2'd0,
    OP_QUERY    = 2'd1,
    OP_SPECTRUM = 2'd2
  } op_t;

  // what the front tells the back about one item
  typedef struct packed {
    op_t              op;
    logic [BIN_W-1:0] top_bin;
  } kct_ctl_t;

  // back-pressure seen by the front
  typedef struct packed {
    logic full;
    logic clearing;
  } kct_fstat_t;

endpackage

FILE: src/kct_front.sv
`timescale 1ns / 1ps

module kct_front #(
  parameter int KEY_WIDTH = 16,
  parameter int MAX_BINS  = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kct_pkg::CMD_W-1:0]        in_command,
  input  logic [kct_pkg::KMER_W-1:0]       in_kmer,
  input  logic                             cfg_we,
  input  logic [kct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kct_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  kct_pkg::kct_fstat_t              fstat,
  output logic                             push,
  output kct_pkg::kct_ctl_t                push_ctl,
  output logic [KEY_WIDTH-1:0]             push_key
);
  import kct_pkg::*;

  localparam logic [5:0]        KW6   = 6'(KEY_WIDTH);
  localparam logic [BINS_W-1:0] MAXB7 = BINS_W'(MAX_BINS);

  logic [KEYB_W-1:0]    key_bits_r;
  logic [BINS_W-1:0]    spectrum_bins_r;
  logic [5:0]           kb_eff;
  logic [BINS_W-1:0]    nb_eff;
  logic [BINS_W-1:0]    top7;
  logic [KEY_WIDTH-1:0] key_mask;
  logic                 cmd_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bits_r      <= KEY_BITS_RST;
      spectrum_bins_r <= BINS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_BITS:      key_bits_r      <= cfg_data[KEYB_W-1:0];
        CFG_SPECTRUM_BINS: spectrum_bins_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp both registers into their working range
  always_comb begin
    kb_eff = {1'b0, key_bits_r};
    if (kb_eff == 6'd0) kb_eff = 6'd1;
    else if (kb_eff > KW6) kb_eff = KW6;
    nb_eff = spectrum_bins_r;
    if (nb_eff == '0) nb_eff = BINS_W'(1);
    else if (nb_eff > MAXB7) nb_eff = MAXB7;
    top7 = nb_eff - BINS_W'(1);
  end

  always_comb begin
    for (int i = 0; i < KEY_WIDTH; i++) begin
      key_mask[i] = (6'(i) < kb_eff);
    end
  end

  always_comb begin
    unique case (in_command) inside
      OP_ADD, OP_QUERY, OP_SPECTRUM: cmd_ok = 1'b1;
      default:                       cmd_ok = 1'b0;
    endcase
  end

  // unused command codes are taken and dropped
  assign in_stall         = fstat.full || fstat.clearing;
  assign push             = in_valid && !in_stall && cmd_ok;
  assign push_ctl.op      = op_t'(in_command);
  assign push_ctl.top_bin = top7[BIN_W-1:0];
  assign push_key         = in_kmer[KEY_WIDTH-1:0] & key_mask;

endmodule

FILE: src/kct_queue.sv
`timescale 1ns / 1ps

module kct_queue #(
  parameter int WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  import kct_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam logic [PTR_W:0] DEPTH_C = (PTR_W + 1)'(Q_DEPTH);

  logic [WIDTH-1:0] slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   fill_r;

  assign full     = (fill_r == DEPTH_C);
  assign empty    = (fill_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      fill_r <= fill_r + 1'b1;
      else if (pop && !push) fill_r <= fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: src/kct_back.sv
`timescale 1ns / 1ps

module kct_back #(
  parameter int KEY_WIDTH = 16,
  parameter int MAX_BINS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  kct_pkg::kct_ctl_t             q_ctl,
  input  logic [KEY_WIDTH-1:0]          q_key,
  output logic                          q_pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kct_pkg::COUNT_W-1:0]   out_count,
  output logic [kct_pkg::COUNT_W-1:0]   out_peak_count,
  output logic [kct_pkg::MAXK_W-1:0]    out_max_kmer,
  output logic [kct_pkg::BIN_W-1:0]     out_bin_index,
  output logic [kct_pkg::TALLY_W-1:0]   out_bin_total,
  output logic [kct_pkg::TALLY_W-1:0]   out_distinct_total,
  output logic                          out_last
);
  import kct_pkg::*;

  localparam longint unsigned DEPTH = 64'd1 << KEY_WIDTH;
  localparam logic [KEY_WIDTH-1:0] ADDR_LAST = '1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RMW   = 6'b000100,
    S_WALK  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   mem_r [DEPTH];
  logic [COUNT_W-1:0]   rd_r;
  logic                 rv_r;
  logic [KEY_WIDTH-1:0] scan_r;
  logic [KEY_WIDTH-1:0] key_r;
  op_t                  op_r;
  logic [BIN_W-1:0]     top_r;
  logic [BIN_W-1:0]     emit_r;
  logic [COUNT_W-1:0]   best_count_r;
  logic [MAXK_W-1:0]    best_kmer_r;
  logic [TALLY_W-1:0]   distinct_r;
  logic [TALLY_W-1:0]   lane_r [MAX_BINS];
  logic                 out_valid_r;

  logic                 mem_re, mem_we;
  logic [KEY_WIDTH-1:0] mem_ra, mem_wa;
  logic [COUNT_W-1:0]   mem_wd;
  logic                 load_rmw, load_emit, start_spec;
  logic                 slot_free;
  logic [COUNT_W-1:0]   new_cnt;
  logic                 new_best;
  logic [BIN_W-1:0]     wbin;
  logic                 tally;

  assign slot_free = !out_valid_r || !out_stall;
  assign new_cnt   = (rd_r == COUNT_MAX) ? rd_r : rd_r + 1'b1;
  assign new_best  = (op_r == OP_ADD) && (new_cnt > best_count_r);
  assign wbin      = (rd_r >= COUNT_W'(top_r)) ? top_r : rd_r[BIN_W-1:0];
  assign tally     = rv_r && (rd_r != '0);
  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    mem_re     = 1'b0;
    mem_ra     = scan_r;
    mem_we     = 1'b0;
    mem_wa     = scan_r;
    mem_wd     = '0;
    load_rmw   = 1'b0;
    load_emit  = 1'b0;
    start_spec = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (scan_r == ADDR_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_ctl.op) inside
            OP_ADD, OP_QUERY: begin
              mem_re    = 1'b1;
              mem_ra    = q_key;
              state_nxt = S_RMW;
            end
            OP_SPECTRUM: begin
              start_spec = 1'b1;
              state_nxt  = S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_RMW: begin
        if (slot_free) begin
          load_rmw  = 1'b1;
          mem_we    = (op_r == OP_ADD);
          mem_wa    = key_r;
          mem_wd    = new_cnt;
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        mem_re = 1'b1;
        if (scan_r == ADDR_LAST) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          load_emit = 1'b1;
          if (emit_r == top_r) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= mem_r[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      scan_r       <= '0;
      rv_r         <= 1'b0;
      emit_r       <= '0;
      best_count_r <= '0;
      best_kmer_r  <= '0;
      distinct_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= (state_r == S_WALK);
      if (start_spec) scan_r <= '0;
      else if (state_r == S_CLEAR || state_r == S_WALK) scan_r <= scan_r + 1'b1;
      if (start_spec) distinct_r <= '0;
      else if (tally && distinct_r != TALLY_MAX) distinct_r <= distinct_r + 1'b1;
      if (start_spec) emit_r <= '0;
      else if (load_emit) emit_r <= emit_r + 1'b1;
      if (load_rmw && new_best) begin
        best_count_r <= new_cnt;
        best_kmer_r  <= MAXK_W'(key_r);
      end
      if (load_rmw || load_emit) out_valid_r <= 1'b1;
      else if (!out_stall)       out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      key_r <= q_key;
      op_r  <= q_ctl.op;
    end
    if (start_spec) top_r <= q_ctl.top_bin;
    if (load_rmw) begin
      out_count          <= (op_r == OP_ADD) ? new_cnt : rd_r;
      out_peak_count     <= new_best ? new_cnt : best_count_r;
      out_max_kmer       <= new_best ? MAXK_W'(key_r) : best_kmer_r;
      out_bin_index      <= '0;
      out_bin_total      <= '0;
      out_distinct_total <= '0;
      out_last           <= 1'b1;
    end else if (load_emit) begin
      out_count          <= '0;
      out_peak_count     <= best_count_r;
      out_max_kmer       <= best_kmer_r;
      out_bin_index      <= emit_r;
      out_bin_total      <= lane_r[0];
      out_distinct_total <= distinct_r;
      out_last           <= (emit_r == top_r);
    end
  end

  // one tally lane per bin, shifted towards lane 0 while the bins go out
  for (genvar k = 0; k < MAX_BINS; k++) begin : g_lane
    localparam int NXT = (k == MAX_BINS - 1) ? k : k + 1;
    always_ff @(posedge clk) begin
      if (start_spec) begin
        lane_r[k] <= '0;
      end else if (load_emit) begin
        lane_r[k] <= (k == MAX_BINS - 1) ? '0 : lane_r[NXT];
      end else if (tally && wbin == BIN_W'(k) && lane_r[k] != TALLY_MAX) begin
        lane_r[k] <= lane_r[k] + 1'b1;
      end
    end
  end

endmodule

FILE: src/kmer_count_table_top.sv
`timescale 1ns / 1ps
// add and query: the count is read, then S_RMW registers the result (waiting while the output is stalled);
//   no new item is popped before that (one count memory read per item, one write for an add)
// spectrum: walk all count addresses, drain, then one result per bin per cycle while not stalled
// reset (rst_n low, synchronous) starts a clearing pass over every address of the count
//   memory; in_stall stays high until it ends, configuration writes are taken throughout

module kmer_count_table_top #(
  parameter int KEY_WIDTH = 16,
  parameter int MAX_BINS  = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kct_pkg::CMD_W-1:0]       in_command,
  input  logic [kct_pkg::KMER_W-1:0]      in_kmer,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kct_pkg::COUNT_W-1:0]     out_count,
  output logic [kct_pkg::COUNT_W-1:0]     out_peak_count,
  output logic [kct_pkg::MAXK_W-1:0]      out_max_kmer,
  output logic [kct_pkg::BIN_W-1:0]       out_bin_index,
  output logic [kct_pkg::TALLY_W-1:0]     out_bin_total,
  output logic [kct_pkg::TALLY_W-1:0]     out_distinct_total,
  output logic                            out_last,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [kct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kct_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kct_pkg::*;

  // queue entry: control word on top, masked key below
  localparam int CTL_W = $bits(kct_ctl_t);
  localparam int QW    = CTL_W + KEY_WIDTH;

  kct_fstat_t           fstat;
  logic                 push;
  kct_ctl_t             push_ctl;
  logic [KEY_WIDTH-1:0] push_key;
  logic [QW-1:0]        pop_data;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  logic                 clearing;
  kct_ctl_t             q_ctl;
  logic [KEY_WIDTH-1:0] q_key;

  // front: config registers, key masking, command check, stall while full or clearing
  kct_front #(
    .KEY_WIDTH (KEY_WIDTH),
    .MAX_BINS  (MAX_BINS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_kmer    (in_kmer),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fstat      (fstat),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_key   (push_key)
  );

  assign fstat.full     = q_full;
  assign fstat.clearing = clearing;

  // short queue so the front keeps taking items while the back is busy
  kct_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctl, push_key}),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign q_ctl = kct_ctl_t'(pop_data[QW-1 -: CTL_W]);
  assign q_key = pop_data[KEY_WIDTH-1:0];

  // back: count memory, read-modify-write, spectrum walk and the output register
  kct_back #(
    .KEY_WIDTH (KEY_WIDTH),
    .MAX_BINS  (MAX_BINS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_ctl              (q_ctl),
    .q_key              (q_key),
    .q_pop              (q_pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_count          (out_count),
    .out_peak_count     (out_peak_count),
    .out_max_kmer       (out_max_kmer),
    .out_bin_index      (out_bin_index),
    .out_bin_total      (out_bin_total),
    .out_distinct_total (out_distinct_total),
    .out_last           (out_last)
  );

endmodule

FILE: src/kct_checker.sv
`timescale 1ns / 1ps
`include "kmer_count_table_top_macros.svh"

module kct_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [kct_pkg::COUNT_W-1:0]     out_count,
  input logic [kct_pkg::COUNT_W-1:0]     out_peak_count,
  input logic [kct_pkg::BIN_W-1:0]       out_bin_index,
  input logic [kct_pkg::TALLY_W-1:0]     out_bin_total,
  input logic [kct_pkg::TALLY_W-1:0]     out_distinct_total,
  input logic                            out_last
);
  import kct_pkg::*;

  // a stalled item holds
  `KCT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_count) && $stable(out_bin_index) && $stable(out_bin_total) && $stable(out_last))
  // no count ever exceeds the tracked maximum
  `KCT_ASSERT_IMP(a_count_le_max, out_valid, out_count <= out_peak_count)
  // a bin never holds more k-mers than the distinct total
  `KCT_ASSERT_IMP(a_bin_le_distinct, out_valid, out_bin_total <= out_distinct_total)
  // only spectrum items have results before the last, and they carry no count
  `KCT_ASSERT_IMP(a_spec_zero_count, out_valid && !out_last, out_count == '0)

endmodule

bind kmer_count_table_top kct_checker u_kct_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_count          (out_count),
  .out_peak_count     (out_peak_count),
  .out_bin_index      (out_bin_index),
  .out_bin_total      (out_bin_total),
  .out_distinct_total (out_distinct_total),
  .out_last           (out_last)
);
